// File: rtl/sitd_pkg.sv
`default_nettype none

package sitd_pkg;

    // ASCII codes
    localparam logic [7:0] CHAR_ZERO  = 8'd48;
    localparam logic [7:0] CHAR_MINUS = 8'd45;

    // commands from controller to datapath
    typedef struct packed {
        logic load;        // take a new value, form magnitude
        logic shift;       // one shift-add-3 step
        logic emit_sign;   // put '-' into the output register
        logic emit_digit;  // put the current top digit into the output register
    } sitd_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic conv_last;   // this shift step is the final one
        logic neg;         // value is negative
        logic digit_last;  // current digit is the least significant one
        logic out_free;    // output register can take a character this cycle
    } sitd_sts_t;

endpackage

`default_nettype wire

// File: rtl/sitd_dp.sv
`default_nettype none

module sitd_dp
    import sitd_pkg::*;
#(
    parameter int DATA_WIDTH = 32
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic [DATA_WIDTH-1:0] value,
    input  wire sitd_cmd_t             cmd,
    output sitd_sts_t                  sts,
    input  wire logic                  out_ready,
    output logic                       out_valid,
    output logic [7:0]                 out_char,
    output logic                       out_last
);

    // decimal digits needed for any DATA_WIDTH-bit unsigned value
    localparam int ND = ((DATA_WIDTH * 1233) >> 12) + 1;
    localparam int IW = $clog2(ND);
    localparam int CW = $clog2(DATA_WIDTH);

    logic [DATA_WIDTH-1:0] mag_reg;
    logic                  neg_reg;
    logic [4*ND-1:0]       bcd_reg;
    logic [IW-1:0]         top_reg;   // index of the most significant digit
    logic [CW-1:0]         bit_cnt_reg;
    logic                  out_valid_reg;
    logic [7:0]            out_char_reg;
    logic                  out_last_reg;

    logic [4*ND-1:0]       bcd_adj;
    logic [3:0]            top_digit;
    logic                  sign_in;
    logic [DATA_WIDTH-1:0] mag_load;

    assign sign_in   = value[DATA_WIDTH-1];
    // two's complement negate; the most negative value maps onto 2^(W-1) exactly
    assign mag_load  = sign_in ? (~value + 1'b1) : value;
    assign top_digit = bcd_reg[{top_reg, 2'b00} +: 4];

    always_comb
    begin
        for (int i = 0; i < ND; i++)
        begin
            bcd_adj[4*i +: 4] = (bcd_reg[4*i +: 4] >= 4'd5) ?
                                (bcd_reg[4*i +: 4] + 4'd3) : bcd_reg[4*i +: 4];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_cnt_reg <= '0;
            top_reg     <= '0;
        end
        else if (cmd.load)
        begin
            bit_cnt_reg <= CW'(DATA_WIDTH - 1);
            top_reg     <= '0;
        end
        else if (cmd.shift)
        begin
            bit_cnt_reg <= bit_cnt_reg - 1'b1;
            // a top digit of 5 or more carries into a new digit when doubled
            if (top_digit >= 4'd5 && top_reg != IW'(ND - 1))
            begin
                top_reg <= top_reg + 1'b1;
            end
        end
        else if (cmd.emit_digit && top_reg != '0)
        begin
            top_reg <= top_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mag_reg <= mag_load;
            neg_reg <= sign_in;
            bcd_reg <= '0;
        end
        else if (cmd.shift)
        begin
            mag_reg <= {mag_reg[DATA_WIDTH-2:0], 1'b0};
            bcd_reg <= {bcd_adj[4*ND-2:0], mag_reg[DATA_WIDTH-1]};
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit_sign || cmd.emit_digit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_sign)
        begin
            out_char_reg <= CHAR_MINUS;
            out_last_reg <= 1'b0;
        end
        else if (cmd.emit_digit)
        begin
            out_char_reg <= CHAR_ZERO + {4'b0000, top_digit};
            out_last_reg <= (top_reg == '0);
        end
    end

    assign sts.conv_last  = (bit_cnt_reg == '0);
    assign sts.neg        = neg_reg;
    assign sts.digit_last = (top_reg == '0);
    assign sts.out_free   = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_char  = out_char_reg;
    assign out_last  = out_last_reg;

endmodule

`default_nettype wire

// File: rtl/sitd_ctrl.sv
`default_nettype none

module sitd_ctrl
    import sitd_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire sitd_sts_t sts,
    output sitd_cmd_t      cmd
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_CONV  = 2'd1;
    localparam logic [1:0] S_SIGN  = 2'd2;
    localparam logic [1:0] S_DIGIT = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        in_ready       = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CONV;
                end
            end
            S_CONV:
            begin
                cmd.shift = 1'b1;
                if (sts.conv_last)
                begin
                    state_next = S_SIGN;
                end
            end
            S_SIGN:
            begin
                if (!sts.neg)
                begin
                    state_next = S_DIGIT;
                end
                else if (sts.out_free)
                begin
                    cmd.emit_sign = 1'b1;
                    state_next    = S_DIGIT;
                end
            end
            S_DIGIT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_digit = 1'b1;
                    if (sts.digit_last)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.shift, cmd.emit_sign, cmd.emit_digit}))
        else $error("more than one datapath command at once");

    a_load_conv: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> (state_reg == S_CONV))
        else $error("load not followed by conversion");

    a_sign_neg: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_sign |-> sts.neg)
        else $error("minus sign for a non-negative value");

    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit_digit && sts.digit_last) |=> (state_reg == S_IDLE))
        else $error("final digit did not return to idle");

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit_sign || cmd.emit_digit) |-> sts.out_free)
        else $error("character written over a pending one");

endmodule

`default_nettype wire

// File: rtl/signed_int_to_decimal_ascii.sv
// Conversion: the input is taken in idle, then the shift-add-3 loop takes one magnitude bit per
//   cycle; a negative value then puts its sign into the output register, and the digits follow.
// Characters leave one per cycle while the output register is free; a new value is not taken
//   until the final digit has been written into the output register.
// The next input is taken while the final character still waits in the output register.
// Reset (rst_n, async, active low) returns the controller to idle and empties the output register.
`default_nettype none

module signed_int_to_decimal_ascii
    import sitd_pkg::*;
#(
    parameter int DATA_WIDTH = 32
)
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // slave side: one signed integer per transaction
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [((DATA_WIDTH+7)/8)*8-1:0]     s_tdata,  // [DATA_WIDTH-1:0] value
    // master side: one ASCII character per transaction
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic [7:0]                               m_tdata,  // [7:0] char_code
    output logic                                     m_tlast   // final character of the number
);

    sitd_cmd_t cmd;
    sitd_sts_t sts;

    // Controller: idle -> conversion (DATA_WIDTH shift steps) -> optional sign -> digits.
    sitd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Datapath: magnitude shift register, BCD accumulator with running digit count,
    // and the output register that decouples the master side.
    sitd_dp #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .value     (s_tdata[DATA_WIDTH-1:0]),
        .cmd       (cmd),
        .sts       (sts),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_char  (m_tdata),
        .out_last  (m_tlast)
    );

endmodule

`default_nettype wire
